// ===== rtl/core/perspective_point_projection_defines.svh =====
// Assertion macros for the file that checks this block.
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

// Checked only while the block is out of reset.
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/ppp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [31:0] ScreenReset = 32'd70780800;

  // Quotient bits of the pixel divide and the stage count of one axis lane:
  // multiply, saturation check, one stage per quotient bit, result.
  localparam int unsigned QuoBits  = 32;
  localparam int unsigned AxisStgs = QuoBits + 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_01 = 3'd0,
    REG_ROW0_23 = 3'd1,
    REG_ROW1_01 = 3'd2,
    REG_ROW1_23 = 3'd3,
    REG_ROW3_01 = 3'd4,
    REG_ROW3_23 = 3'd5,
    REG_SCREEN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic               on_screen;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/perspective_point_projection.sv =====
// Perspective point projection.
// A world point (pos_x, pos_y, pos_z, signed fixed point) enters on the input
// channel; one word leaves on the output channel for every word taken: the
// on_screen flag and the pixel coordinates screen_x and screen_y. A point
// whose homogeneous w lies below the near threshold comes out with the flag
// clear and both coordinates zero.
// The matrix rows and screen size are written on the plain write port; the
// user must write only while no word is in flight, which the block does not
// check. A write takes effect at once. One word enters per cycle while the
// pipeline has room: three stages form the dot products, near-plane test and
// numerators, two more the scaled numerator and its saturation check, and each
// axis then runs a 32-stage restoring divide, one quotient bit per stage.
// Every stage holds a valid bit and moves when its successor has room, so a
// stalled receiver only freezes the words behind the output register and
// empty stages still fill up. Reset clears all valid bits and loads the
// identity-free default matrix of zeros and a 1920 x 1080 screen.
`timescale 1ns / 1ps
`default_nettype none
module perspective_point_projection #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire ppp_pkg::in_t                       in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output ppp_pkg::out_t                           out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ppp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [ppp_pkg::CfgDataW-1:0]       cfg_data_i
);
  import ppp_pkg::*;

  // Width of a dot-product sum: three floored products and a coefficient.
  localparam int DW      = 66 - FRAC_BITS;
  localparam int ThrRaw  = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int Thr     = (ThrRaw < 1) ? 1 : ThrRaw;
  localparam int STG     = 3 + AxisStgs;

  // Configuration registers: six coefficient words and the screen size.
  logic [63:0] coef_q [6];
  logic [31:0] screen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        coef_q[i] <= '0;
      end
      screen_q <= ScreenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_ROW0_01: coef_q[0] <= cfg_data_i;
        REG_ROW0_23: coef_q[1] <= cfg_data_i;
        REG_ROW1_01: coef_q[2] <= cfg_data_i;
        REG_ROW1_23: coef_q[3] <= cfg_data_i;
        REG_ROW3_01: coef_q[4] <= cfg_data_i;
        REG_ROW3_23: coef_q[5] <= cfg_data_i;
        REG_SCREEN:  screen_q  <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // Stage valid bits; a stage moves when it is empty or its successor moves.
  logic [STG-1:0] v_q;
  logic [STG:0]   en;

  assign en[STG] = out_ready_i;
  for (genvar k = 0; k < STG; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < STG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[STG-1];

  // Stage 0: nine coefficient by coordinate products. Row index 0 is x,
  // 1 is y and 2 is w (matrix row 3).
  logic signed [31:0] pos [3];
  logic signed [63:0] prod [3][3];
  logic signed [63:0] p_q  [3][3];

  always_comb begin
    pos[0] = in_data_i.pos_x;
    pos[1] = in_data_i.pos_y;
    pos[2] = in_data_i.pos_z;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod[k][c] = 64'($signed(coef_q[2*k + c/2][32*(c%2) +: 32])) * 64'(pos[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q <= prod;
    end
  end

  // Stage 1: floor each product to the point format and add column 3.
  logic signed [DW-1:0] dot [3];
  logic signed [DW-1:0] dot_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dot[k] = DW'(p_q[k][0] >>> FRAC_BITS) + DW'(p_q[k][1] >>> FRAC_BITS)
             + DW'(p_q[k][2] >>> FRAC_BITS) + DW'($signed(coef_q[2*k+1][63:32]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dot_q <= dot;
    end
  end

  // Stage 2: near-plane test and the numerators w + x and w - y.
  logic signed [DW-1:0] w_q;
  logic signed [DW:0]   numx_q;
  logic signed [DW:0]   numy_q;
  logic                 vis_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      w_q    <= dot_q[2];
      numx_q <= (DW+1)'(dot_q[2]) + (DW+1)'(dot_q[0]);
      numy_q <= (DW+1)'(dot_q[2]) - (DW+1)'(dot_q[1]);
      vis_q  <= dot_q[2] >= DW'(Thr);
    end
  end

  // Each axis scales its numerator by the screen size and divides by 2w.
  logic               visx;
  logic               visy;
  logic signed [31:0] resx;
  logic signed [31:0] resy;

  ppp_axis #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_axis_x (
    .clk_i  (clk_i),
    .adv_i  (en[STG-1:3]),
    .vis_i  (vis_q),
    .num_i  (numx_q),
    .w_i    (w_q),
    .size_i (screen_q[15:0]),
    .vis_o  (visx),
    .res_o  (resx)
  );

  ppp_axis #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_axis_y (
    .clk_i  (clk_i),
    .adv_i  (en[STG-1:3]),
    .vis_i  (vis_q),
    .num_i  (numy_q),
    .w_i    (w_q),
    .size_i (screen_q[31:16]),
    .vis_o  (visy),
    .res_o  (resy)
  );

  // Both lanes carry the same flag; the output flag is the AND of the two copies.
  always_comb begin
    out_data_o.on_screen = visx & visy;
    out_data_o.screen_x  = resx;
    out_data_o.screen_y  = resy;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ppp_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppp_axis #(
  parameter int FRAC_BITS = 16,
  parameter int DW        = 50
) (
  input  wire logic                               clk_i,
  input  wire logic [ppp_pkg::AxisStgs-1:0]       adv_i,
  input  wire logic                               vis_i,
  input  wire logic signed [DW:0]                 num_i,
  input  wire logic signed [DW-1:0]               w_i,
  input  wire logic [15:0]                        size_i,
  output logic                                    vis_o,
  output logic signed [31:0]                      res_o
);
  import ppp_pkg::*;

  localparam int MW   = DW + 1;
  localparam int NW   = MW + 16 + FRAC_BITS;
  localparam int CW   = NW + QuoBits;
  localparam int NSTG = AxisStgs;

  // Per-stage remainder, divisor, quotient and flags.
  logic [NW-1:0]      r_q   [NSTG-1];
  logic [DW-1:0]      d_q   [NSTG-1];
  logic [QuoBits-1:0] q_q   [NSTG-1];
  logic               neg_q [NSTG-1];
  logic               sat_q [NSTG-1];
  logic               vis_q [NSTG-1];
  logic signed [31:0] res_q;
  logic               visf_q;

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    if (j == 0) begin : g_mul
      logic [MW-1:0]    mag;
      logic [MW+15:0]   prod;
      always_comb begin
        mag  = num_i[DW] ? MW'(~num_i + 1'b1) : MW'(num_i);
        prod = (MW+16)'(mag) * (MW+16)'(size_i);
      end
      always_ff @(posedge clk_i) begin
        if (adv_i[j]) begin
          r_q[j]   <= {prod, {FRAC_BITS{1'b0}}};
          d_q[j]   <= {w_i[DW-2:0], 1'b0};
          q_q[j]   <= '0;
          neg_q[j] <= num_i[DW];
          sat_q[j] <= 1'b0;
          vis_q[j] <= vis_i;
        end
      end
    end else if (j == 1) begin : g_sat
      logic [CW-1:0] lim;
      logic          sat;
      always_comb begin
        lim = CW'(d_q[j-1]) << (QuoBits - 1);
        sat = neg_q[j-1] ? (CW'(r_q[j-1]) > lim) : (CW'(r_q[j-1]) >= lim);
      end
      always_ff @(posedge clk_i) begin
        if (adv_i[j]) begin
          r_q[j]   <= r_q[j-1];
          d_q[j]   <= d_q[j-1];
          q_q[j]   <= q_q[j-1];
          neg_q[j] <= neg_q[j-1];
          sat_q[j] <= sat;
          vis_q[j] <= vis_q[j-1];
        end
      end
    end else if (j < NSTG - 1) begin : g_div
      localparam int Bit = QuoBits + 1 - j;
      logic [CW-1:0]      t;
      logic               ge;
      logic [QuoBits-1:0] qn;
      always_comb begin
        t      = CW'(d_q[j-1]) << Bit;
        ge     = CW'(r_q[j-1]) >= t;
        qn     = q_q[j-1];
        qn[Bit] = ge;
      end
      always_ff @(posedge clk_i) begin
        if (adv_i[j]) begin
          r_q[j]   <= ge ? NW'(CW'(r_q[j-1]) - t) : r_q[j-1];
          d_q[j]   <= d_q[j-1];
          q_q[j]   <= qn;
          neg_q[j] <= neg_q[j-1];
          sat_q[j] <= sat_q[j-1];
          vis_q[j] <= vis_q[j-1];
        end
      end
    end else begin : g_res
      logic [31:0] qf;
      logic [31:0] res;
      always_comb begin
        qf = q_q[j-1] + 32'(|r_q[j-1]);
        if (!vis_q[j-1]) begin
          res = '0;
        end else if (sat_q[j-1]) begin
          res = neg_q[j-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (neg_q[j-1]) begin
          res = 32'd0 - qf;
        end else begin
          res = q_q[j-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i[j]) begin
          res_q  <= res;
          visf_q <= vis_q[j-1];
        end
      end
    end
  end

  assign res_o = res_q;
  assign vis_o = visf_q;

endmodule
`default_nettype wire

// ===== rtl/core/ppp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "perspective_point_projection_defines.svh"
module ppp_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic                               in_ready_o,
  input  wire ppp_pkg::in_t                       in_data_i,
  input  wire logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  input  wire ppp_pkg::out_t                      out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ppp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [ppp_pkg::CfgDataW-1:0]       cfg_data_i
);
  import ppp_pkg::*;

  // A stalled output word stays put.
  `PPP_ASSERT(a_out_hold,
              out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o),
              "output word changed while stalled")

  // A point behind the near plane carries zero coordinates.
  `PPP_ASSERT(a_off_zero,
              out_valid_o && !out_data_o.on_screen |->
                out_data_o.screen_x == 32'sd0 && out_data_o.screen_y == 32'sd0,
              "off-screen word has nonzero coordinates")

  // With the receiver taking words the pipeline never pushes back.
  `PPP_ASSERT(a_ready_flow, out_ready_i |-> in_ready_o, "input stalled while output drains")

  // Nothing leaves during reset.
  `PPP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (.*);
`default_nettype wire

// ===== verif/perspective_point_projection_tb.sv =====
`timescale 1ns / 1ps
module perspective_point_projection_tb;
  import ppp_pkg::*;

  localparam int FracBits = 16;
  // The near threshold is one thousandth of unity, rounded, at least one LSB.
  localparam longint NearThr = ((longint'(1) << FracBits) + 500) / 1000;
  localparam longint One = longint'(1) << FracBits;
  // An index past the last register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;
  localparam logic signed [127:0] SatMax = 128'sd2147483647;
  localparam logic signed [127:0] SatMin = -128'sd2147483648;
  // Slack allowed after the last match before a register write.
  localparam int DrainCycles = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  perspective_point_projection #(.FRAC_BITS(FracBits)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the register file, updated on every write we issue to a valid index.
  logic [CfgDataW-1:0] cfg_shadow [7];

  in_t  pending_pts [$];
  out_t expected_px [$];
  int   err_cnt;
  // When set, the matching side runs without gaps or stalls.
  bit   send_burst;
  bit   recv_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fetch one signed coefficient word from the shadow registers.
  function automatic longint coef_word(int idx, bit upper);
    logic signed [31:0] c;
    c = upper ? cfg_shadow[idx][63:32] : cfg_shadow[idx][31:0];
    return longint'(c);
  endfunction

  // Dot product of one matrix row with the point. Each product is floored to
  // the fraction width before the exact 64-bit sum; column 3 adds unscaled.
  function automatic longint row_sum(int r01, int r23, in_t p);
    longint acc;
    acc = (coef_word(r01, 0) * longint'(p.pos_x)) >>> FracBits;
    acc += (coef_word(r01, 1) * longint'(p.pos_y)) >>> FracBits;
    acc += (coef_word(r23, 0) * longint'(p.pos_z)) >>> FracBits;
    acc += coef_word(r23, 1);
    return acc;
  endfunction

  // floor(num * size * 2^F / (2w)), saturated to the signed 32-bit range.
  function automatic logic [31:0] pixel_axis(longint num, logic [15:0] size, longint w);
    logic signed [127:0] n;
    logic signed [127:0] d;
    logic signed [127:0] q;
    n = num;
    n = n * $signed({112'd0, size});
    n = n <<< FracBits;
    d = w;
    d = d * 2;
    q = n / d;
    // Division truncates toward zero; the pixel map floors.
    if (n < 0 && (n % d) != 0) q = q - 1;
    if (q > SatMax) return 32'h7FFF_FFFF;
    if (q < SatMin) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic out_t project_point(in_t p);
    out_t   r;
    longint w;
    longint x;
    longint y;
    r = '0;
    w = row_sum(REG_ROW3_01, REG_ROW3_23, p);
    // Below the near threshold: flag clear and both coordinates zero.
    if (w < NearThr) return r;
    x = row_sum(REG_ROW0_01, REG_ROW0_23, p);
    y = row_sum(REG_ROW1_01, REG_ROW1_23, p);
    r.on_screen = 1'b1;
    r.screen_x  = pixel_axis(w + x, cfg_shadow[REG_SCREEN][15:0], w);
    r.screen_y  = pixel_axis(w - y, cfg_shadow[REG_SCREEN][31:16], w);
    return r;
  endfunction

  // Driver: one word per item, followed by a drawn gap.
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) expected_px.push_back(project_point(in_data_i));
      if (in_valid_i && !in_ready_o) begin
        // Hold the word until it is taken.
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_pts.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_pts.pop_front();
        send_gap   <= send_burst ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check every accepted word against the oldest prediction, then
  // draw a stall for the receiver.
  int   recv_stall;
  int   stall_draw;
  out_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
      recv_stall  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_px.size() == 0) begin
        $error("unexpected output word %h", out_data_o);
        err_cnt++;
      end else begin
        want = expected_px.pop_front();
        if (out_data_o.on_screen !== want.on_screen) begin
          $error("on_screen: expected %0d, got %0d", want.on_screen, out_data_o.on_screen);
          err_cnt++;
        end
        if (out_data_o.screen_x !== want.screen_x) begin
          $error("screen_x: expected %0d, got %0d", want.screen_x, out_data_o.screen_x);
          err_cnt++;
        end
        if (out_data_o.screen_y !== want.screen_y) begin
          $error("screen_y: expected %0d, got %0d", want.screen_y, out_data_o.screen_y);
          err_cnt++;
        end
      end
      stall_draw = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall_draw > 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= stall_draw;
      end
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      if (recv_stall == 1) out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx <= REG_SCREEN) begin
      cfg_shadow[idx] = data;
      if (idx == REG_SCREEN) cfg_shadow[idx][63:32] = '0;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every point is sent and every prediction has been matched, then
  // let the pipeline settle.
  task automatic drain();
    while (pending_pts.size() > 0 || in_valid_i || expected_px.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_point(longint px, longint py, longint pz);
    in_t p;
    p.pos_x = px[31:0];
    p.pos_y = py[31:0];
    p.pos_z = pz[31:0];
    pending_pts.push_back(p);
  endtask

  // Either a full 32-bit word or a small value within about +-4.0.
  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  // A random matrix; row 3 is mostly kept so that w is positive, which is
  // where the divide path gets exercised.
  task automatic random_matrix();
    logic [31:0] wc;
    for (int r = REG_ROW0_01; r <= REG_ROW1_23; r++) begin
      write_reg(CfgIdxW'(r), {rand_word(), rand_word()});
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_ROW3_01, {rand_word(), rand_word()});
      write_reg(REG_ROW3_23, {rand_word(), rand_word()});
    end else begin
      wc = $urandom_range(32'h0001_0000, 32'h0040_0000);
      write_reg(REG_ROW3_01, {32'($urandom_range(0, 32'h2000)) - 32'h1000,
                              32'($urandom_range(0, 32'h2000)) - 32'h1000});
      write_reg(REG_ROW3_23, {wc, 32'($urandom_range(0, 32'h2000)) - 32'h1000});
    end
  endtask

  initial begin
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    err_cnt     = 0;
    send_burst  = 1'b0;
    recv_burst  = 1'b0;
    for (int i = 0; i < 7; i++) cfg_shadow[i] = '0;
    cfg_shadow[REG_SCREEN] = {32'd0, ScreenReset};
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset matrix is all zeros, so w is zero and nothing is visible.
    add_point(0, 0, 0);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // Plain perspective: x, y pass through and w equals z.
    write_reg(REG_ROW0_01, {32'd0, 32'(One)});
    write_reg(REG_ROW0_23, 64'd0);
    write_reg(REG_ROW1_01, {32'(One), 32'd0});
    write_reg(REG_ROW1_23, 64'd0);
    write_reg(REG_ROW3_01, 64'd0);
    write_reg(REG_ROW3_23, {32'd0, 32'(One)});
    write_reg(RegNone, 64'hFFFF_FFFF_FFFF_FFFF);
    add_point(0, 0, One);
    add_point(One, -One, One);
    add_point(-One, One, 2 * One);
    add_point(0, 0, NearThr);          // exactly at the near threshold
    add_point(0, 0, NearThr - 1);      // just behind it
    add_point(0, 0, -One);             // behind the camera
    add_point(32'h7FFF_FFFF, 32'h8000_0000, NearThr);  // saturates on both axes
    add_point(32'h8000_0000, 32'h7FFF_FFFF, NearThr);
    add_point(-3, 5, 32'h7FFF_FFFF);   // rounds toward minus infinity
    add_point(32'hFFFF_FFFF, 32'h0000_0001, One);
    drain();

    // Zero screen, then the largest screen.
    write_reg(REG_SCREEN, 64'hFFFF_FFFF_0000_0000);
    add_point(One, One, One);
    add_point(-One, -One, One);
    drain();
    write_reg(REG_SCREEN, 64'h0000_0000_FFFF_FFFF);
    add_point(One, One, One);
    add_point(-One, -One, One);
    add_point(32'h0012_3456, -32'h0001_2345, 32'h0000_1000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_matrix();
      case (ph % 4)
        0: write_reg(REG_SCREEN, {32'd0, 16'd1080, 16'd1920});
        1: write_reg(REG_SCREEN, {32'd0, $urandom()});
        2: write_reg(REG_SCREEN, {$urandom(), 32'hFFFF_0000 | $urandom_range(0, 15)});
        default: write_reg(REG_SCREEN, {$urandom(), $urandom()});
      endcase
      send_burst = (ph == 3);
      recv_burst = (ph == 5);
      for (int k = 0; k < 66; k++) begin
        if ($urandom_range(0, 3) == 0)
          add_point($urandom(), $urandom(), $urandom());
        else
          add_point(longint'($signed(rand_word())), longint'($signed(rand_word())),
                    $urandom_range(0, 32'h0008_0000));
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
